// File: hw/rtl/ars_pkg.sv
// ars_pkg: shared types and constants for the at response status scanner
// keyword strings, capture codes, link codes and the keyword hit struct
// no dependencies
package ars_pkg;

    localparam int WINDOW_BYTES_DEF = 13;
    localparam int KW_MAX = 13;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [8*2-1:0]  KW_OK     = "OK";
    localparam logic [8*5-1:0]  KW_ERROR  = "ERROR";
    localparam logic [8*5-1:0]  KW_BUSY   = "busy ";
    localparam logic [8*7-1:0]  KW_STATUS = "STATUS:";
    localparam logic [8*6-1:0]  KW_WIFI_C = "WIFI C";
    localparam logic [8*6-1:0]  KW_WIFI_D = "WIFI D";
    localparam logic [8*6-1:0]  KW_WIFI_G = "WIFI G";
    localparam logic [8*2-1:0]  KW_PROMPT = {CH_LF, ">"};
    localparam logic [8*13-1:0] KW_CWMODE = {CH_LF, "+CWMODE", "_CUR:"};
    localparam logic [8*13-1:0] KW_CWDHCP = {CH_LF, "+CWDHCP", "_CUR:"};
    localparam logic [8*9-1:0]  KW_CIPMUX = {CH_LF, "+CIPMUX:"};
    localparam logic [8*10-1:0] KW_CIPMOD = {CH_LF, "+CIPMODE:"};
    localparam logic [8*12-1:0] KW_CWSAP  = {CH_LF, "+CWSAP", "_CUR:"};
    localparam logic [8*9-1:0]  KW_CIPSTO = {CH_LF, "+CIPSTO:"};
    localparam logic [8*8-1:0]  KW_CWJAP  = {CH_LF, "+CWJAP:"};

    typedef enum logic [2:0] {
        CAP_NONE   = 3'd0,
        CAP_STATUS = 3'd1,
        CAP_MODE   = 3'd2,
        CAP_DHCP   = 3'd3,
        CAP_MUX    = 3'd4,
        CAP_IPMODE = 3'd5,
        CAP_AP     = 3'd6,
        CAP_TMO    = 3'd7
    } t_capture;

    localparam logic [1:0] LINK_DISC   = 2'd0;
    localparam logic [1:0] LINK_GOT_IP = 2'd1;
    localparam logic [1:0] LINK_CONN   = 2'd2;
    localparam logic [1:0] LINK_FAILED = 2'd3;

    localparam logic [2:0] FIELD_CHAN = 3'd2;
    localparam logic [2:0] FIELD_ENC  = 3'd3;
    localparam logic [2:0] FIELD_END  = 3'd4;
    localparam logic [2:0] FIELD_SAT  = 3'd7;

    typedef struct packed {
        logic ok;
        logic error;
        logic busy;
        logic status;
        logic wifi_c;
        logic wifi_d;
        logic wifi_g;
        logic prompt;
        logic cwmode;
        logic cwdhcp;
        logic cipmux;
        logic cipmode;
        logic cwsap;
        logic cipsto;
        logic cwjap;
    } t_hits;

endpackage

// File: hw/rtl/ars_cell.sv
// ars_cell: one byte cell of the receive window chain
// takes its neighbor's byte on each beat, clears at the end of a reply
// depends on nothing
module ars_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_shift) begin
            n_byte = i_clear ? 8'h00 : i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: hw/rtl/ars_match.sv
// ars_match: keyword compare against the newest bytes of the window
// depends on ars_pkg
module ars_match (
    input  logic [8*ars_pkg::KW_MAX-1:0] i_tail,
    output ars_pkg::t_hits               o_hits
);
    import ars_pkg::*;

    // newest byte sits in the low bits of i_tail
    always_comb begin
        o_hits.ok      = i_tail[8*2-1:0]  == KW_OK;
        o_hits.error   = i_tail[8*5-1:0]  == KW_ERROR;
        o_hits.busy    = i_tail[8*5-1:0]  == KW_BUSY;
        o_hits.status  = i_tail[8*7-1:0]  == KW_STATUS;
        o_hits.wifi_c  = i_tail[8*6-1:0]  == KW_WIFI_C;
        o_hits.wifi_d  = i_tail[8*6-1:0]  == KW_WIFI_D;
        o_hits.wifi_g  = i_tail[8*6-1:0]  == KW_WIFI_G;
        o_hits.prompt  = i_tail[8*2-1:0]  == KW_PROMPT;
        o_hits.cwmode  = i_tail[8*13-1:0] == KW_CWMODE;
        o_hits.cwdhcp  = i_tail[8*13-1:0] == KW_CWDHCP;
        o_hits.cipmux  = i_tail[8*9-1:0]  == KW_CIPMUX;
        o_hits.cipmode = i_tail[8*10-1:0] == KW_CIPMOD;
        o_hits.cwsap   = i_tail[8*12-1:0] == KW_CWSAP;
        o_hits.cipsto  = i_tail[8*9-1:0]  == KW_CIPSTO;
        o_hits.cwjap   = i_tail[8*8-1:0]  == KW_CWJAP;
    end

endmodule

// File: hw/rtl/at_response_status_scanner.sv
// at_response_status_scanner: top level, byte window chain, keyword match, capture logic
// the result of a byte is registered into the output register when the byte is taken
// throughput: one byte per cycle unless the output register holds a result not taken
// a new byte is taken while a result waits whenever the output register is taken or empty
// reset (synchronous, active low) zeroes the window, flags, link state, captures and timeout
// depends on ars_pkg, ars_cell, ars_match
module at_response_status_scanner #(
    parameter int WINDOW_BYTES = ars_pkg::WINDOW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    input  logic        i_clear_ok,
    input  logic        i_clear_error,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok_seen,
    output logic        o_error_seen,
    output logic [3:0]  o_net_status,
    output logic [1:0]  o_link_state,
    output logic        o_transparent_on,
    output logic [3:0]  o_wifi_mode,
    output logic [3:0]  o_dhcp_mode,
    output logic [3:0]  o_mux_mode,
    output logic [3:0]  o_ip_mode,
    output logic [3:0]  o_ap_channel,
    output logic [3:0]  o_ap_encryption,
    output logic [15:0] o_server_timeout
);
    import ars_pkg::*;

    logic                  acc;
    logic [7:0]            win    [WINDOW_BYTES];
    logic [7:0]            nwin   [WINDOW_BYTES];
    logic [8*KW_MAX-1:0]   tail;
    t_hits                 hits;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;

    // window chain, oldest byte in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_BYTES; gi++) begin : g_cell
            if (gi == WINDOW_BYTES - 1) begin : g_head
                assign nwin[gi] = i_rx_byte;
            end else begin : g_body
                assign nwin[gi] = win[gi+1];
            end
            ars_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (acc),
                .i_clear (i_last_byte),
                .i_byte  (nwin[gi]),
                .o_byte  (win[gi])
            );
        end
        for (gi = 0; gi < KW_MAX; gi++) begin : g_tail
            assign tail[8*gi +: 8] = nwin[WINDOW_BYTES-1-gi];
        end
    endgenerate

    ars_match u_match (
        .i_tail (tail),
        .o_hits (hits)
    );

    logic        r_ok, r_err, r_trans;
    logic [1:0]  r_link;
    logic [3:0]  r_status, r_mode, r_dhcp, r_mux, r_ipm, r_chan, r_enc;
    t_capture    r_pend;
    logic [2:0]  r_comma;
    logic [15:0] r_tmo;
    logic        r_out_valid;

    logic        n_ok, n_err, n_trans;
    logic [1:0]  n_link;
    logic [3:0]  n_status, n_mode, n_dhcp, n_mux, n_ipm, n_chan, n_enc;
    t_capture    n_pend;
    logic [2:0]  n_comma;
    logic [15:0] n_tmo;
    logic        res_ok, res_err;
    logic [19:0] tmo_sum;
    logic        is_digit;

    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign tmo_sum  = ({4'b0, r_tmo} << 3) + ({4'b0, r_tmo} << 1) + {16'b0, i_rx_byte[3:0]};

    always_comb begin
        n_ok     = r_ok;
        n_err    = r_err;
        n_trans  = r_trans;
        n_link   = r_link;
        n_status = r_status;
        n_mode   = r_mode;
        n_dhcp   = r_dhcp;
        n_mux    = r_mux;
        n_ipm    = r_ipm;
        n_chan   = r_chan;
        n_enc    = r_enc;
        n_pend   = r_pend;
        n_comma  = r_comma;
        n_tmo    = r_tmo;

        // capture of the pending reply field
        unique case (r_pend)
            CAP_NONE: begin
            end
            CAP_STATUS: begin
                n_status = i_rx_byte[3:0];
                n_pend   = CAP_NONE;
            end
            CAP_MODE: begin
                n_mode = i_rx_byte[3:0];
                n_pend = CAP_NONE;
            end
            CAP_DHCP: begin
                n_dhcp = i_rx_byte[3:0];
                n_pend = CAP_NONE;
            end
            CAP_MUX: begin
                n_mux  = i_rx_byte[3:0];
                n_pend = CAP_NONE;
            end
            CAP_IPMODE: begin
                n_ipm  = i_rx_byte[3:0];
                n_pend = CAP_NONE;
            end
            CAP_AP: begin
                if (i_rx_byte == CH_COMMA) begin
                    if (r_comma != FIELD_SAT) begin
                        n_comma = r_comma + 3'd1;
                    end
                end else if (i_rx_byte != CH_QUOTE) begin
                    if (r_comma == FIELD_CHAN) begin
                        n_chan = i_rx_byte[3:0];
                    end else if (r_comma == FIELD_ENC) begin
                        n_enc = i_rx_byte[3:0];
                    end else if (r_comma == FIELD_END) begin
                        n_pend = CAP_NONE;
                    end
                end
            end
            CAP_TMO: begin
                if (is_digit) begin
                    n_tmo = (|tmo_sum[19:16]) ? 16'hffff : tmo_sum[15:0];
                end else begin
                    n_pend = CAP_NONE;
                end
            end
            default: begin
            end
        endcase

        // keyword hits, later ones win
        if (hits.ok)     n_ok = 1'b1;
        if (hits.error)  n_err = 1'b1;
        if (hits.busy)   n_ok = 1'b0;
        if (hits.status) n_pend = CAP_STATUS;
        if (hits.wifi_c) n_link = LINK_CONN;
        if (hits.wifi_d) n_link = LINK_DISC;
        if (hits.wifi_g) n_link = LINK_GOT_IP;
        if (hits.prompt) n_trans = 1'b1;
        if (hits.cwmode) n_pend = CAP_MODE;
        if (hits.cwdhcp) n_pend = CAP_DHCP;
        if (hits.cipmux) n_pend = CAP_MUX;
        if (hits.cipmode) n_pend = CAP_IPMODE;
        if (hits.cwsap) begin
            n_pend  = CAP_AP;
            n_comma = 3'd0;
        end
        if (hits.cipsto) begin
            n_pend = CAP_TMO;
            n_tmo  = 16'd0;
        end
        if (hits.cwjap)  n_link = LINK_FAILED;

        res_ok  = n_ok;
        res_err = n_err;
        if (i_clear_ok)    n_ok = 1'b0;
        if (i_clear_error) n_err = 1'b0;
        if (i_last_byte) begin
            n_pend  = CAP_NONE;
            n_comma = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok        <= 1'b0;
            r_err       <= 1'b0;
            r_trans     <= 1'b0;
            r_link      <= LINK_DISC;
            r_status    <= 4'd0;
            r_mode      <= 4'd0;
            r_dhcp      <= 4'd0;
            r_mux       <= 4'd0;
            r_ipm       <= 4'd0;
            r_chan      <= 4'd0;
            r_enc       <= 4'd0;
            r_pend      <= CAP_NONE;
            r_comma     <= 3'd0;
            r_tmo       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_ok     <= n_ok;
                r_err    <= n_err;
                r_trans  <= n_trans;
                r_link   <= n_link;
                r_status <= n_status;
                r_mode   <= n_mode;
                r_dhcp   <= n_dhcp;
                r_mux    <= n_mux;
                r_ipm    <= n_ipm;
                r_chan   <= n_chan;
                r_enc    <= n_enc;
                r_pend   <= n_pend;
                r_comma  <= n_comma;
                r_tmo    <= n_tmo;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            o_ok_seen        <= res_ok;
            o_error_seen     <= res_err;
            o_net_status     <= n_status;
            o_link_state     <= n_link;
            o_transparent_on <= n_trans;
            o_wifi_mode      <= n_mode;
            o_dhcp_mode      <= n_dhcp;
            o_mux_mode       <= n_mux;
            o_ip_mode        <= n_ipm;
            o_ap_channel     <= n_chan;
            o_ap_encryption  <= n_enc;
            o_server_timeout <= n_tmo;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: dv/tb_at_response_status_scanner.sv
// tb_at_response_status_scanner: self-checking bench for the at response status scanner
// streams modem reply text with sender bursts and receiver stalls, predicts every status beat
// depends on ars_pkg and at_response_status_scanner
`timescale 1ns / 1ps

module tb_at_response_status_scanner;

    import ars_pkg::*;

    localparam int WIN = WINDOW_BYTES_DEF;
    localparam int STIM_BYTES = 1850;

    localparam string RPL_MODE = {string'("+CWMODE"), "_CUR:"};
    localparam string RPL_DHCP = {string'("+CWDHCP"), "_CUR:"};
    localparam string RPL_SAP  = {string'("+CWSAP"), "_CUR:"};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       clr_ok;
        logic       clr_err;
    } t_beat;

    typedef struct packed {
        logic        ok;
        logic        err;
        logic [3:0]  net;
        logic [1:0]  link;
        logic        trans;
        logic [3:0]  wmode;
        logic [3:0]  dhcp;
        logic [3:0]  mux;
        logic [3:0]  ipm;
        logic [3:0]  chan;
        logic [3:0]  enc;
        logic [15:0] sto;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_clear_ok = 1'b0;
    logic        i_clear_error = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_ok_seen;
    logic        o_error_seen;
    logic [3:0]  o_net_status;
    logic [1:0]  o_link_state;
    logic        o_transparent_on;
    logic [3:0]  o_wifi_mode;
    logic [3:0]  o_dhcp_mode;
    logic [3:0]  o_mux_mode;
    logic [3:0]  o_ip_mode;
    logic [3:0]  o_ap_channel;
    logic [3:0]  o_ap_encryption;
    logic [15:0] o_server_timeout;

    at_response_status_scanner u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_last_byte      (i_last_byte),
        .i_clear_ok       (i_clear_ok),
        .i_clear_error    (i_clear_error),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ok_seen        (o_ok_seen),
        .o_error_seen     (o_error_seen),
        .o_net_status     (o_net_status),
        .o_link_state     (o_link_state),
        .o_transparent_on (o_transparent_on),
        .o_wifi_mode      (o_wifi_mode),
        .o_dhcp_mode      (o_dhcp_mode),
        .o_mux_mode       (o_mux_mode),
        .o_ip_mode        (o_ip_mode),
        .o_ap_channel     (o_ap_channel),
        .o_ap_encryption  (o_ap_encryption),
        .o_server_timeout (o_server_timeout)
    );

    always #5 i_clk = ~i_clk;

    t_beat       byte_q[$];
    t_status     status_q[$];
    int unsigned n_queued = 0;
    int unsigned replies = 0;
    int unsigned beats_in = 0;
    int unsigned n_checked = 0;
    int unsigned n_bad = 0;

    // scanner state mirror
    logic [8*WIN-1:0] scan_win = '0;
    logic             flag_ok = 1'b0;
    logic             flag_err = 1'b0;
    logic             flag_trans = 1'b0;
    logic [1:0]       link_code = LINK_DISC;
    logic [3:0]       net_r = '0;
    logic [3:0]       wmode_r = '0;
    logic [3:0]       dhcp_r = '0;
    logic [3:0]       mux_r = '0;
    logic [3:0]       ipm_r = '0;
    logic [3:0]       chan_r = '0;
    logic [3:0]       enc_r = '0;
    t_capture         cap_pend = CAP_NONE;
    logic [2:0]       field_cnt = '0;
    logic [15:0]      sto_acc = '0;

    function automatic logic tail_is(input string kw);
        int  n;
        logic m;
        n = kw.len();
        m = 1'b1;
        if (n > WIN) begin
            return 1'b0;
        end
        for (int k = 0; k < n; k++) begin
            if (scan_win[8*(n-1-k) +: 8] != kw[k]) begin
                m = 1'b0;
            end
        end
        return m;
    endfunction

    task automatic scan_byte(input t_beat bt, output t_status res);
        logic [7:0]  ch;
        logic [31:0] acc;
        ch = bt.ch;
        case (cap_pend)
            CAP_STATUS: begin net_r = ch[3:0]; cap_pend = CAP_NONE; end
            CAP_MODE: begin wmode_r = ch[3:0]; cap_pend = CAP_NONE; end
            CAP_DHCP: begin dhcp_r = ch[3:0]; cap_pend = CAP_NONE; end
            CAP_MUX: begin mux_r = ch[3:0]; cap_pend = CAP_NONE; end
            CAP_IPMODE: begin ipm_r = ch[3:0]; cap_pend = CAP_NONE; end
            CAP_AP: begin
                if (ch == CH_COMMA) begin
                    if (field_cnt != FIELD_SAT) begin
                        field_cnt = field_cnt + 3'd1;
                    end
                end else if (ch != CH_QUOTE) begin
                    if (field_cnt == FIELD_CHAN) begin
                        chan_r = ch[3:0];
                    end else if (field_cnt == FIELD_ENC) begin
                        enc_r = ch[3:0];
                    end else if (field_cnt == FIELD_END) begin
                        cap_pend = CAP_NONE;
                    end
                end
            end
            CAP_TMO: begin
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    acc = sto_acc * 32'd10 + (ch - CH_ZERO);
                    sto_acc = (acc > 32'd65535) ? 16'hffff : acc[15:0];
                end else begin
                    cap_pend = CAP_NONE;
                end
            end
            default: ;
        endcase
        scan_win = {scan_win[8*(WIN-1)-1:0], ch};
        if (tail_is("OK")) flag_ok = 1'b1;
        if (tail_is("ERROR")) flag_err = 1'b1;
        if (tail_is("busy ")) flag_ok = 1'b0;
        if (tail_is("STATUS:")) cap_pend = CAP_STATUS;
        if (tail_is("WIFI C")) link_code = LINK_CONN;
        if (tail_is("WIFI D")) link_code = LINK_DISC;
        if (tail_is("WIFI G")) link_code = LINK_GOT_IP;
        if (tail_is("\n>")) flag_trans = 1'b1;
        if (tail_is({"\n", RPL_MODE})) cap_pend = CAP_MODE;
        if (tail_is({"\n", RPL_DHCP})) cap_pend = CAP_DHCP;
        if (tail_is("\n+CIPMUX:")) cap_pend = CAP_MUX;
        if (tail_is("\n+CIPMODE:")) cap_pend = CAP_IPMODE;
        if (tail_is({"\n", RPL_SAP})) begin
            cap_pend = CAP_AP;
            field_cnt = '0;
        end
        if (tail_is("\n+CIPSTO:")) begin
            cap_pend = CAP_TMO;
            sto_acc = '0;
        end
        if (tail_is("\n+CWJAP:")) link_code = LINK_FAILED;
        res = '{flag_ok, flag_err, net_r, link_code, flag_trans, wmode_r, dhcp_r, mux_r,
                ipm_r, chan_r, enc_r, sto_acc};
        if (bt.clr_ok) flag_ok = 1'b0;
        if (bt.clr_err) flag_err = 1'b0;
        if (bt.last) begin
            scan_win = '0;
            cap_pend = CAP_NONE;
            field_cnt = '0;
        end
    endtask

    function automatic string show(input t_status s);
        return {$sformatf("ok=%b err=%b net=%h link=%h tr=%b mode=%h ",
                          s.ok, s.err, s.net, s.link, s.trans, s.wmode),
                $sformatf("dhcp=%h mux=%h ipm=%h ch=%h enc=%h sto=%0d",
                          s.dhcp, s.mux, s.ipm, s.chan, s.enc, s.sto)};
    endfunction

    // stimulus helpers
    task automatic push_beat(input logic [7:0] ch, input logic last,
                             input logic co, input logic ce);
        byte_q.push_back('{ch, last, co, ce});
        n_queued++;
        if (last) replies++;
    endtask

    task automatic push_ch(input logic [7:0] ch);
        push_beat(ch, 1'b0, $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_ch(s[k]);
        end
    endtask

    task automatic push_eol();
        push_ch(8'h0d);
        push_ch(CH_LF);
    endtask

    task automatic push_digit();
        if ($urandom_range(0, 3) == 0) begin
            push_ch(8'($urandom_range(0, 255)));
        end else begin
            push_ch(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    task automatic push_word(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                push_ch(8'($urandom_range(0, 255)));
            end else begin
                push_ch(8'("a" + $urandom_range(0, 25)));
            end
        end
    endtask

    task automatic end_reply();
        t_beat t;
        t = byte_q.pop_back();
        t.last = 1'b1;
        byte_q.push_back(t);
        replies++;
    endtask

    task automatic push_query(input string kw);
        push_eol();
        push_text(kw);
        push_digit();
        push_eol();
        push_eol();
        push_text("OK");
        push_eol();
    endtask

    task automatic push_reply();
        int unsigned v;
        case ($urandom_range(0, 15))
            0: begin push_eol(); push_text("OK"); push_eol(); end
            1: begin push_eol(); push_text("ERROR"); push_eol(); end
            2: begin push_text("busy p..."); push_eol(); end
            3: begin push_text("STATUS:"); push_digit(); push_eol(); end
            4: begin push_text("WIFI CONNECTED"); push_eol(); end
            5: begin push_text("WIFI DISCONNECT"); push_eol(); end
            6: begin push_text("WIFI GOT IP"); push_eol(); end
            7: begin push_eol(); push_ch(">"); end
            8: push_query(RPL_MODE);
            9: push_query(RPL_DHCP);
            10: begin
                if ($urandom_range(0, 1) != 0) begin
                    push_query("+CIPMUX:");
                end else begin
                    push_query("+CIPMODE:");
                end
            end
            11: begin
                push_eol();
                push_text({RPL_SAP, "\""});
                push_word($urandom_range(0, 8));
                push_text("\",\"");
                push_word($urandom_range(0, 8));
                push_text("\",");
                push_text($sformatf("%0d", $urandom_range(1, 14)));
                push_ch(",");
                push_digit();
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 8)) push_ch(",");
                    push_word($urandom_range(1, 4));
                end else begin
                    push_ch(",");
                    push_digit();
                    push_text(",0");
                end
                push_eol();
                push_eol();
                push_text("OK");
                push_eol();
            end
            12: begin
                push_eol();
                push_text("+CIPSTO:");
                v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999999)
                                                : $urandom_range(0, 999);
                push_text($sformatf("%0d", v));
                case ($urandom_range(0, 3))
                    0: push_ch("-");
                    1: push_ch(" ");
                    2: push_ch(8'($urandom_range(0, 255)));
                    default: push_eol();
                endcase
                push_text("OK");
            end
            13: begin push_eol(); push_text("+CWJAP:"); push_digit(); push_eol(); push_text("FAIL"); end
            14: begin
                // keyword on the final byte, then a digit that must not be captured
                push_eol();
                if ($urandom_range(0, 1) != 0) begin
                    push_text("+CIPMUX:");
                end else begin
                    push_text("+CIPSTO:");
                end
                end_reply();
                push_digit();
                push_text("OK");
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: repeat ($urandom_range(1, 12)) push_ch(8'($urandom_range(0, 255)));
                    1: begin push_eol(); push_text("+CWMO"); push_digit(); end
                    default: begin push_text("+CIPMODE:"); push_digit(); end
                endcase
            end
        endcase
        if ($urandom_range(0, 3) != 0) end_reply();
    endtask

    // sender
    logic        in_beat = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    t_beat       cur;

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_beat)) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (byte_q.size() != 0) begin
                cur = byte_q.pop_front();
                i_rx_byte <= cur.ch;
                i_last_byte <= cur.last;
                i_clear_ok <= cur.clr_ok;
                i_clear_error <= cur.clr_err;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    logic [5:0] stall_cnt = '0;
    logic [1:0] stall_mode = '0;

    always @(negedge i_clk) begin
        stall_cnt <= stall_cnt + 6'd1;
        if (stall_cnt == '0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= 1'($urandom_range(0, 1));
            2'd2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (stall_cnt[2:0] > 3'd4);
        endcase
    end

    // monitor: check the output beat first, then predict the input beat
    t_status got;
    t_status want;
    t_status pred;

    always @(posedge i_clk) begin
        in_beat <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_ok_seen, o_error_seen, o_net_status, o_link_state, o_transparent_on,
                        o_wifi_mode, o_dhcp_mode, o_mux_mode, o_ip_mode, o_ap_channel,
                        o_ap_encryption, o_server_timeout};
                n_checked++;
                if (status_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected result beat: %s", show(got));
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("mismatch on result %0d", n_checked);
                            $display("  exp %s", show(want));
                            $display("  act %s", show(got));
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                scan_byte('{i_rx_byte, i_last_byte, i_clear_ok, i_clear_error}, pred);
                status_q.push_back(pred);
                beats_in++;
            end
        end
    end

    initial begin
        // byte extremes, a prompt without and with a line feed, then OK, ERROR and busy text
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'hff, 1'b1, 1'b1, 1'b1);
        push_beat(">", 1'b0, 1'b0, 1'b0);
        push_beat(CH_LF, 1'b0, 1'b0, 1'b0);
        push_beat(">", 1'b1, 1'b0, 1'b0);
        push_beat("O", 1'b0, 1'b0, 1'b0);
        push_beat("K", 1'b0, 1'b1, 1'b0);
        push_beat("E", 1'b0, 1'b0, 1'b0);
        push_beat("R", 1'b0, 1'b0, 1'b0);
        push_beat("R", 1'b0, 1'b0, 1'b0);
        push_beat("O", 1'b0, 1'b0, 1'b0);
        push_beat("R", 1'b0, 1'b0, 1'b1);
        push_beat("O", 1'b0, 1'b0, 1'b0);
        push_beat("K", 1'b0, 1'b0, 1'b0);
        push_beat("b", 1'b0, 1'b0, 1'b0);
        push_beat("u", 1'b0, 1'b0, 1'b0);
        push_beat("s", 1'b0, 1'b0, 1'b0);
        push_beat("y", 1'b0, 1'b0, 1'b0);
        push_beat(" ", 1'b0, 1'b0, 1'b0);
        push_beat("E", 1'b0, 1'b0, 1'b0);
        push_beat("R", 1'b0, 1'b0, 1'b0);
        push_beat("R", 1'b0, 1'b0, 1'b0);
        push_beat("O", 1'b0, 1'b0, 1'b0);
        push_beat("R", 1'b1, 1'b1, 1'b1);
        while (n_queued < STIM_BYTES + 24) begin
            push_reply();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("scanned %0d bytes in %0d replies under random sender gaps and receiver stalls",
                 beats_in, replies);
        $display("%0d status beats compared, %0d mismatches", n_checked, n_bad);
        if (n_bad == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d bytes and %0d results outstanding", byte_q.size(),
                 status_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
